FILE: rtl/rmth_pkg.sv
package rmth_pkg;

  localparam int unsigned HeapDepthDef = 512;
  localparam int unsigned ValW         = 32;
  localparam int unsigned CountW       = 11;

  typedef logic signed [ValW-1:0] val_t;
  typedef logic [CountW-1:0]      count_t;

  // heap select
  localparam logic SelLower = 1'b0;
  localparam logic SelUpper = 1'b1;

endpackage

FILE: rtl/rmth_if.sv
interface rmth_in_if;
  import rmth_pkg::*;
  logic valid;
  logic ready;
  val_t value;
  logic start_req;
  modport source(output valid, value, start_req, input ready);
  modport sink(input valid, value, start_req, output ready);
endinterface

interface rmth_out_if;
  import rmth_pkg::*;
  logic   valid;
  logic   ready;
  val_t   median;
  count_t count;
  logic   overflow;
  modport source(output valid, median, count, overflow, input ready);
  modport sink(input valid, median, count, overflow, output ready);
endinterface

FILE: rtl/rmth_ram.sv
module rmth_ram #(
  parameter int unsigned DEPTH  = rmth_pkg::HeapDepthDef,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [ADDR_W-1:0]     waddr_i,
  input  rmth_pkg::val_t        wdata_i,
  input  logic [ADDR_W-1:0]     raddr_i,
  output rmth_pkg::val_t        rdata_o
);
  import rmth_pkg::*;

  val_t mem_q [DEPTH];
  val_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/rmth_seq.sv
module rmth_seq #(
  parameter int unsigned HEAP_DEPTH = rmth_pkg::HeapDepthDef,
  parameter int unsigned ADDR_W     = $clog2(HEAP_DEPTH),
  parameter int unsigned FILL_W     = $clog2(HEAP_DEPTH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  rmth_pkg::val_t        in_value_i,
  input  logic                  in_start_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output rmth_pkg::val_t        out_median_o,
  output rmth_pkg::count_t      out_count_o,
  output logic                  out_overflow_o,
  output logic [1:0]            we_o,
  output logic [ADDR_W-1:0]     waddr_o,
  output rmth_pkg::val_t        wdata_o,
  output logic [ADDR_W-1:0]     raddr_o,
  input  rmth_pkg::val_t        rdata_lo_i,
  input  rmth_pkg::val_t        rdata_up_i
);
  import rmth_pkg::*;

  localparam int unsigned IDX_W = FILL_W + 1;
  localparam logic [FILL_W-1:0] FullFill = FILL_W'(HEAP_DEPTH);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_INS_STEP = 9'b000000010,
    S_INS_CMP  = 9'b000000100,
    S_INS_DONE = 9'b000001000,
    S_TOP_CMP  = 9'b000010000,
    S_REM_LD   = 9'b000100000,
    S_REM_STEP = 9'b001000000,
    S_REM_L    = 9'b010000000,
    S_REM_R    = 9'b100000000
  } state_e;

  // the one-cycle result load that ends each word is encoded via the done flag
  state_e state_q, state_d;
  logic   done_q, done_d;
  logic   sel_q, sel_d;
  logic   pend_q, pend_d;
  logic   ovf_q, ovf_d;
  logic   even_q, even_d;
  logic   has_q, has_d;
  logic   lwin_q, lwin_d;
  logic [FILL_W-1:0] fill_q [2];
  logic [FILL_W-1:0] fill_d [2];
  logic [FILL_W-1:0] k_q, k_d, n_q, n_d;
  val_t   med_q, med_d, x_q, x_d, v_q, v_d, cv_q, cv_d;

  logic   ovalid_q, ovalid_d;
  val_t   omed_q, omed_d;
  count_t ocnt_q, ocnt_d;
  logic   oovf_q, oovf_d;

  // shared compare unit: true when a must sit above b (min mode: a < b)
  logic cmp_min;
  val_t cmp_a, cmp_b;
  logic win;
  assign win = cmp_min ? (cmp_a < cmp_b) : (cmp_b < cmp_a);

  val_t rdata;
  assign rdata = sel_q ? rdata_up_i : rdata_lo_i;

  logic [IDX_W-1:0] l_idx, r_idx;
  logic [FILL_W-1:0] p_idx;
  assign l_idx = {k_q, 1'b1};
  assign r_idx = l_idx + IDX_W'(1);
  assign p_idx = (k_q - FILL_W'(1)) >> 1;

  logic acc;
  assign in_ready_o = (state_q == S_IDLE) && !done_q && !ovalid_q;
  assign acc        = in_valid_i && in_ready_o;

  always_comb begin
    unique case (state_q)
      S_IDLE:    begin cmp_min = SelUpper; cmp_a = in_value_i; cmp_b = med_q; end
      S_INS_CMP: begin cmp_min = sel_q;    cmp_a = v_q;        cmp_b = rdata; end
      S_TOP_CMP: begin cmp_min = sel_q;    cmp_a = x_q;        cmp_b = rdata; end
      S_REM_L:   begin cmp_min = sel_q;    cmp_a = rdata;      cmp_b = v_q;   end
      S_REM_R:   begin
        cmp_min = sel_q;
        cmp_a   = rdata;
        cmp_b   = lwin_q ? cv_q : v_q;
      end
      default:   begin cmp_min = sel_q;    cmp_a = v_q;        cmp_b = rdata; end
    endcase
  end

  always_comb begin
    logic wr;
    logic [FILL_W-1:0] waddr;
    val_t wdata;
    logic rem_end;
    wr       = 1'b0;
    waddr    = k_q;
    wdata    = v_q;
    rem_end  = 1'b0;
    raddr_o  = '0;
    state_d  = state_q;
    done_d   = 1'b0;
    sel_d    = sel_q;
    pend_d   = pend_q;
    ovf_d    = ovf_q;
    even_d   = even_q;
    has_d    = has_q;
    lwin_d   = lwin_q;
    fill_d   = fill_q;
    k_d      = k_q;
    n_d      = n_q;
    med_d    = med_q;
    x_d      = x_q;
    v_d      = v_q;
    cv_d     = cv_q;
    ovalid_d = ovalid_q && !out_ready_i;
    omed_d   = omed_q;
    ocnt_d   = ocnt_q;
    oovf_d   = oovf_q;

    if (done_q) begin
      ovalid_d = 1'b1;
      omed_d   = med_q;
      ocnt_d   = CountW'({1'b0, fill_q[0]} + {1'b0, fill_q[1]} + IDX_W'(1));
      oovf_d   = ovf_q;
    end

    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          x_d   = in_value_i;
          ovf_d = 1'b0;
          if (in_start_i || !has_q) begin
            med_d     = in_value_i;
            fill_d[0] = '0;
            fill_d[1] = '0;
            even_d    = 1'b0;
            has_d     = 1'b1;
            done_d    = 1'b1;
          end else if (fill_q[even_q ? SelLower : SelUpper] == FullFill) begin
            ovf_d  = 1'b1;
            done_d = 1'b1;
          end else begin
            sel_d  = even_q ? SelLower : SelUpper;
            even_d = !even_q;
            k_d    = fill_q[sel_d];
            fill_d[sel_d] = fill_q[sel_d] + FILL_W'(1);
            if (even_q ? win : !win) begin
              v_d    = in_value_i;
              pend_d = 1'b0;
            end else begin
              v_d    = med_q;
              pend_d = 1'b1;
            end
            state_d = S_INS_STEP;
          end
        end
      end
      S_INS_STEP: begin
        if (k_q == '0) begin
          wr      = 1'b1;
          state_d = S_INS_DONE;
        end else begin
          raddr_o = ADDR_W'(p_idx);
          state_d = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        wr = 1'b1;
        if (win) begin
          wdata   = rdata;
          k_d     = p_idx;
          state_d = S_INS_STEP;
        end else begin
          state_d = S_INS_DONE;
        end
      end
      S_INS_DONE: begin
        if (pend_q) begin
          pend_d = 1'b0;
          sel_d  = !sel_q;
          if (fill_q[!sel_q] == '0) begin
            med_d   = x_q;
            done_d  = 1'b1;
            state_d = S_IDLE;
          end else begin
            raddr_o = '0;
            state_d = S_TOP_CMP;
          end
        end else begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_TOP_CMP: begin
        if (win) begin
          med_d   = x_q;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          med_d         = rdata;
          n_d           = fill_q[sel_q] - FILL_W'(1);
          fill_d[sel_q] = n_d;
          raddr_o       = ADDR_W'(n_d);
          state_d       = S_REM_LD;
        end
      end
      S_REM_LD: begin
        v_d     = rdata;
        k_d     = '0;
        state_d = S_REM_STEP;
      end
      S_REM_STEP: begin
        if (l_idx >= {1'b0, n_q}) begin
          wr      = 1'b1;
          rem_end = 1'b1;
        end else begin
          raddr_o = ADDR_W'(l_idx);
          state_d = S_REM_L;
        end
      end
      S_REM_L: begin
        lwin_d = win;
        cv_d   = rdata;
        if (r_idx < {1'b0, n_q}) begin
          raddr_o = ADDR_W'(r_idx);
          state_d = S_REM_R;
        end else begin
          wr = 1'b1;
          if (win) begin
            wdata   = rdata;
            k_d     = FILL_W'(l_idx);
            state_d = S_REM_STEP;
          end else begin
            rem_end = 1'b1;
          end
        end
      end
      S_REM_R: begin
        wr = 1'b1;
        if (win) begin
          wdata   = rdata;
          k_d     = FILL_W'(r_idx);
          state_d = S_REM_STEP;
        end else if (lwin_q) begin
          wdata   = cv_q;
          k_d     = FILL_W'(l_idx);
          state_d = S_REM_STEP;
        end else begin
          rem_end = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // root removed, now push the new word into the same heap
    if (rem_end) begin
      k_d           = fill_q[sel_q];
      fill_d[sel_q] = fill_q[sel_q] + FILL_W'(1);
      v_d           = x_q;
      state_d       = S_INS_STEP;
    end

    we_o    = {wr && sel_q, wr && !sel_q};
    waddr_o = ADDR_W'(waddr);
    wdata_o = wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      done_q   <= 1'b0;
      pend_q   <= 1'b0;
      ovf_q    <= 1'b0;
      even_q   <= 1'b0;
      has_q    <= 1'b0;
      fill_q   <= '{default: '0};
      med_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      done_q   <= done_d;
      pend_q   <= pend_d;
      ovf_q    <= ovf_d;
      even_q   <= even_d;
      has_q    <= has_d;
      fill_q   <= fill_d;
      med_q    <= med_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q  <= sel_d;
    lwin_q <= lwin_d;
    k_q    <= k_d;
    n_q    <= n_d;
    x_q    <= x_d;
    v_q    <= v_d;
    cv_q   <= cv_d;
    omed_q <= omed_d;
    ocnt_q <= ocnt_d;
    oovf_q <= oovf_d;
  end

  assign out_valid_o    = ovalid_q;
  assign out_median_o   = omed_q;
  assign out_count_o    = ocnt_q;
  assign out_overflow_o = oovf_q;

endmodule

FILE: rtl/running_median_two_heaps_top.sv
// result path: a start, the first word or a refused word sets the done flag, which loads
// the output register; otherwise the done flag follows one push, plus top check, pop
// and second push when the median moves
// throughput: one word in flight, next word taken once the result is taken
// the single read port of each heap memory sets the rate
// reset: asynchronous active low, clears fills, median, parity and handshakes
module running_median_two_heaps_top #(
  parameter int unsigned HEAP_DEPTH = rmth_pkg::HeapDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rmth_in_if.sink     in_i,
  rmth_out_if.source  out_o
);
  import rmth_pkg::*;

  localparam int unsigned ADDR_W = $clog2(HEAP_DEPTH);

  logic [1:0]        we;
  logic [ADDR_W-1:0] waddr, raddr;
  val_t              wdata, rdata_lo, rdata_up;

  rmth_seq #(
    .HEAP_DEPTH(HEAP_DEPTH),
    .ADDR_W    (ADDR_W)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .in_ready_o    (in_i.ready),
    .in_value_i    (in_i.value),
    .in_start_i    (in_i.start_req),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .out_median_o  (out_o.median),
    .out_count_o   (out_o.count),
    .out_overflow_o(out_o.overflow),
    .we_o          (we),
    .waddr_o       (waddr),
    .wdata_o       (wdata),
    .raddr_o       (raddr),
    .rdata_lo_i    (rdata_lo),
    .rdata_up_i    (rdata_up)
  );

  // max-heap of the lower half
  rmth_ram #(.DEPTH(HEAP_DEPTH), .ADDR_W(ADDR_W)) u_lower (
    .clk_i  (clk_i),
    .we_i   (we[0]),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata_lo)
  );

  // min-heap of the upper half
  rmth_ram #(.DEPTH(HEAP_DEPTH), .ADDR_W(ADDR_W)) u_upper (
    .clk_i  (clk_i),
    .we_i   (we[1]),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata_up)
  );

endmodule

FILE: rtl/rmth_checker.sv
module rmth_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input rmth_pkg::val_t       median_i
);
  import rmth_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // one word in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_acc |=> !in_ready_i)
    else $error("input taken twice in a row");

  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_i |-> !in_ready_i)
    else $error("input ready while a result waits");

  assert property (@(posedge clk_i) disable iff (!rst_ni) in_acc |=> !out_valid_i)
    else $error("result shown in the cycle after the input word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(median_i))
    else $error("stalled result changed");

endmodule

bind running_median_two_heaps_top rmth_checker u_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .median_i   (out_o.median)
);

FILE: tb/sv/tb_running_median_two_heaps_top.sv
`timescale 1ns / 100ps

module tb_running_median_two_heaps_top;
  import rmth_pkg::*;

  localparam int unsigned Depth = HeapDepthDef;

  typedef struct {
    val_t   median;
    count_t count;
    logic   overflow;
  } median_res_t;

  typedef struct {
    val_t   value;
    logic   start;
    bit     typed;
    val_t   median;
    count_t count;
    logic   overflow;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rmth_in_if  in_if();
  rmth_out_if out_if();

  running_median_two_heaps_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #4 clk_i = ~clk_i;

  // predictor state
  val_t        heap_mem [2][Depth];
  int unsigned heap_fill [2];
  val_t        cur_median;
  bit          even_count;
  bit          has_data;

  median_res_t medians_due [$];
  int          fail_count;
  int          send_idle_pct;
  int          recv_stall_pct;
  bit          hold_req;

  // typed word for the next accept, consumed by the input monitor
  bit          next_typed;
  median_res_t next_typed_res;

  function automatic bit ranks_above(logic sel, val_t a, val_t b);
    return (sel == SelLower) ? (a > b) : (a < b);
  endfunction

  function automatic void heap_push(logic sel, val_t v);
    int unsigned k;
    int unsigned p;
    val_t t;
    k = heap_fill[sel];
    heap_mem[sel][k] = v;
    heap_fill[sel] = k + 1;
    while (k > 0) begin
      p = (k - 1) / 2;
      if (!ranks_above(sel, heap_mem[sel][k], heap_mem[sel][p])) break;
      t = heap_mem[sel][k];
      heap_mem[sel][k] = heap_mem[sel][p];
      heap_mem[sel][p] = t;
      k = p;
    end
  endfunction

  function automatic val_t heap_pop(logic sel);
    int unsigned n;
    int unsigned k;
    int unsigned best;
    val_t root;
    val_t t;
    n = heap_fill[sel] - 1;
    root = heap_mem[sel][0];
    heap_mem[sel][0] = heap_mem[sel][n];
    heap_fill[sel] = n;
    k = 0;
    forever begin
      best = k;
      if (2*k+1 < n && ranks_above(sel, heap_mem[sel][2*k+1], heap_mem[sel][best])) best = 2*k+1;
      if (2*k+2 < n && ranks_above(sel, heap_mem[sel][2*k+2], heap_mem[sel][best])) best = 2*k+2;
      if (best == k) break;
      t = heap_mem[sel][k];
      heap_mem[sel][k] = heap_mem[sel][best];
      heap_mem[sel][best] = t;
      k = best;
    end
    return root;
  endfunction

  function automatic median_res_t predict_median(val_t x, logic start);
    median_res_t r;
    r.overflow = 1'b0;
    if (start || !has_data) begin
      heap_fill[SelLower] = 0;
      heap_fill[SelUpper] = 0;
      cur_median = x;
      even_count = 1'b0;
      has_data = 1'b1;
    end else if (even_count) begin
      if (heap_fill[SelLower] >= Depth) begin
        r.overflow = 1'b1;
      end else if (x < cur_median) begin
        heap_push(SelLower, x);
        even_count = 1'b0;
      end else begin
        heap_push(SelLower, cur_median);
        if (heap_fill[SelUpper] == 0 || x < heap_mem[SelUpper][0]) begin
          cur_median = x;
        end else begin
          cur_median = heap_pop(SelUpper);
          heap_push(SelUpper, x);
        end
        even_count = 1'b0;
      end
    end else begin
      if (heap_fill[SelUpper] >= Depth) begin
        r.overflow = 1'b1;
      end else if (x < cur_median) begin
        heap_push(SelUpper, cur_median);
        if (heap_fill[SelLower] == 0 || x > heap_mem[SelLower][0]) begin
          cur_median = x;
        end else begin
          cur_median = heap_pop(SelLower);
          heap_push(SelLower, x);
        end
        even_count = 1'b1;
      end else begin
        heap_push(SelUpper, x);
        even_count = 1'b1;
      end
    end
    r.median = cur_median;
    r.count = count_t'(heap_fill[SelLower] + heap_fill[SelUpper] + 1);
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  // input monitor: predicts on every accepted word
  always @(posedge clk_i) begin
    median_res_t r;
    if (rst_ni && in_if.valid && in_if.ready) begin
      r = predict_median(in_if.value, in_if.start_req);
      if (next_typed) begin
        if (r.median !== next_typed_res.median || r.count !== next_typed_res.count ||
            r.overflow !== next_typed_res.overflow)
          report_mismatch("directed row disagrees with predictor");
        medians_due = {medians_due, next_typed_res};
      end else begin
        medians_due = {medians_due, r};
      end
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    median_res_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (medians_due.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        e = medians_due.pop_front();
        if (out_if.median !== e.median)
          report_mismatch($sformatf("median %0d exp %0d", out_if.median, e.median));
        if (out_if.count !== e.count)
          report_mismatch($sformatf("count %0d exp %0d", out_if.count, e.count));
        if (out_if.overflow !== e.overflow)
          report_mismatch($sformatf("overflow %0b exp %0b", out_if.overflow, e.overflow));
      end
    end
  end

  // receiver
  initial begin
    int n;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        for (n = 0; n < 400; n++) @(posedge clk_i);
        hold_req = 1'b0;
      end
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_word(val_t v, logic s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.value <= v;
    in_if.start_req <= s;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  function automatic val_t rand_value();
    case ($urandom_range(5))
      0: return val_t'($urandom_range(7)) - 3;
      1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      2: return val_t'($urandom_range(200)) - 100;
      default: return val_t'($urandom());
    endcase
  endfunction

  stim_row_t directed_rows [] = '{
    '{32'sd5, 1'b0, 1'b1, 32'sd5, 11'd1, 1'b0},
    '{32'sh80000000, 1'b0, 1'b1, 32'sh80000000, 11'd2, 1'b0},
    '{32'sh7fffffff, 1'b0, 1'b1, 32'sd5, 11'd3, 1'b0},
    '{32'sd7, 1'b1, 1'b1, 32'sd7, 11'd1, 1'b0},
    '{32'sd7, 1'b0, 1'b1, 32'sd7, 11'd2, 1'b0},
    '{32'sd7, 1'b0, 1'b1, 32'sd7, 11'd3, 1'b0},
    '{32'sd0, 1'b0, 1'b0, '0, '0, 1'b0},
    '{-32'sd1, 1'b0, 1'b0, '0, '0, 1'b0},
    '{32'sd100, 1'b0, 1'b0, '0, '0, 1'b0},
    '{-32'sd100, 1'b0, 1'b0, '0, '0, 1'b0},
    '{32'sh7fffffff, 1'b0, 1'b0, '0, '0, 1'b0},
    '{32'sh80000000, 1'b0, 1'b0, '0, '0, 1'b0},
    '{32'sd3, 1'b0, 1'b0, '0, '0, 1'b0},
    '{32'sd3, 1'b0, 1'b0, '0, '0, 1'b0},
    '{32'sh80000000, 1'b1, 1'b1, 32'sh80000000, 11'd1, 1'b0},
    '{32'sh7fffffff, 1'b0, 1'b1, 32'sh80000000, 11'd2, 1'b0},
    '{32'sh55555555, 1'b0, 1'b0, '0, '0, 1'b0},
    '{32'shaaaaaaaa, 1'b0, 1'b0, '0, '0, 1'b0}
  };

  initial begin
    int k;
    int len;
    int sent;
    fail_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b0;
    next_typed = 1'b0;
    has_data = 1'b0;
    even_count = 1'b0;
    cur_median = '0;
    heap_fill[SelLower] = 0;
    heap_fill[SelUpper] = 0;
    in_if.valid = 1'b0;
    in_if.value = '0;
    in_if.start_req = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      next_typed <= directed_rows[i].typed;
      next_typed_res <= '{directed_rows[i].median, directed_rows[i].count,
                          directed_rows[i].overflow};
      send_word(directed_rows[i].value, directed_rows[i].start);
    end
    next_typed <= 1'b0;

    // one long sequence fills both heaps and runs into overflow
    sent = 0;
    for (len = 0; len < 1040; len++) begin
      case ((sent / 260) % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      if (sent == 40) hold_req = 1'b1;
      send_word(rand_value(), len == 0);
      sent++;
    end

    // short sequences, some broken by a stray start
    while (sent < 1100) begin
      len = $urandom_range(40, 1);
      for (k = 0; k < len; k++) begin
        case ((sent / 70) % 4)
          0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
          default: begin send_idle_pct = 36; recv_stall_pct = 36; end
        endcase
        send_word(rand_value(), k == 0 || $urandom_range(49) == 0);
        sent++;
      end
    end
    in_if.valid <= 1'b0;
    recv_stall_pct = 0;

    while (medians_due.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
